// ===== src/ordered_list_engine_macros.svh =====
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define OLE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define OLE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ole_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ole_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VALUE_W   = 32;
  localparam int MODE_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DROP   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LENGTH = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] popped_value;
    logic [COUNT_W-1:0]        count;
  } res_t;

endpackage
`default_nettype wire

// ===== src/ole_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ole_mem #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [ole_pkg::VALUE_W-1:0]  wdata,
  input  wire logic [AW-1:0]                raddr,
  output logic      [ole_pkg::VALUE_W-1:0]  rdata
);
  import ole_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  // Read-before-write on a shared address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/ole_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ole_seq #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cmd_valid,
  input  wire logic [ole_pkg::MODE_W-1:0]   cmd_mode,
  input  wire logic [ole_pkg::VALUE_W-1:0]  cmd_value,
  input  wire logic                         out_busy,
  output logic                              idle,
  output logic                              res_valid,
  output ole_pkg::res_t                     res,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic [ole_pkg::VALUE_W-1:0]       mem_wdata,
  output logic [AW-1:0]                     mem_raddr,
  input  wire logic [ole_pkg::VALUE_W-1:0]  mem_rdata
);
  import ole_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_POP, S_SCAN, S_SHIFT} state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [AW-1:0]      wptr_r, wptr_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic               find_r, find_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;

  logic [CW:0]             tail_sum;
  logic [CW:0]             tail_wrap;
  logic [AW-1:0]           tail;
  logic [CW-1:0]           k_inc;
  logic [CW-1:0]           count_dec;
  logic                    full;
  logic                    empty;
  logic                    hit;
  logic [COUNT_W+CW-1:0]   len_ext;
  logic [COUNT_W+CW-1:0]   pos_ext;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // Tail slot: head plus length, folded back once into the ring.
  assign tail_sum  = {{(CW + 1 - AW){1'b0}}, head_r} + {1'b0, count_r};
  assign tail_wrap = tail_sum - (CW + 1)'(DEPTH);
  assign tail      = (tail_sum >= (CW + 1)'(DEPTH)) ? tail_wrap[AW-1:0] : tail_sum[AW-1:0];

  assign k_inc     = k_r + 1'b1;
  assign count_dec = count_r - 1'b1;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign hit       = (mem_rdata == value_r);
  assign len_ext   = {{COUNT_W{1'b0}}, count_r};
  assign pos_ext   = {{COUNT_W{1'b0}}, k_inc};

  assign idle      = (state_r == S_IDLE);
  // Address the next pointer so the registered read data matches ptr_r.
  assign mem_raddr = ptr_nxt;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    wptr_nxt  = wptr_r;
    k_nxt     = k_r;
    find_nxt  = find_r;
    value_nxt = value_r;
    mem_we    = 1'b0;
    mem_waddr = wptr_r;
    mem_wdata = mem_rdata;
    res_valid = 1'b0;
    res       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          value_nxt = cmd_value;
          unique case (cmd_mode) inside
            MODE_APPEND: begin
              res_valid = 1'b1;
              if (full) begin
                res.status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail;
                mem_wdata = cmd_value;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_POP: begin
              if (empty) begin
                res_valid  = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                ptr_nxt   = head_r;
                state_nxt = S_POP;
              end
            end
            MODE_DROP: begin
              res_valid = 1'b1;
              if (empty) begin
                res.status = ST_EMPTY;
              end else begin
                count_nxt = count_dec;
              end
            end
            MODE_DELETE, MODE_FIND: begin
              if (empty) begin
                res_valid  = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                ptr_nxt   = head_r;
                k_nxt     = '0;
                find_nxt  = (cmd_mode == MODE_FIND);
                state_nxt = S_SCAN;
              end
            end
            MODE_LENGTH: begin
              res_valid = 1'b1;
              res.count = len_ext[COUNT_W-1:0];
            end
            MODE_CLEAR: begin
              res_valid = 1'b1;
              count_nxt = '0;
              head_nxt  = '0;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (!out_busy) begin
          res_valid        = 1'b1;
          res.popped_value = mem_rdata;
          head_nxt         = wrap_inc(head_r);
          count_nxt        = count_dec;
          state_nxt        = S_IDLE;
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (find_r) begin
            if (!out_busy) begin
              res_valid = 1'b1;
              res.count = pos_ext[COUNT_W-1:0];
              state_nxt = S_IDLE;
            end
          end else begin
            wptr_nxt  = ptr_r;
            ptr_nxt   = wrap_inc(ptr_r);
            state_nxt = S_SHIFT;
          end
        end else if (k_r == count_dec) begin
          if (!out_busy) begin
            res_valid  = 1'b1;
            res.status = ST_NOTFOUND;
            state_nxt  = S_IDLE;
          end
        end else begin
          k_nxt   = k_inc;
          ptr_nxt = wrap_inc(ptr_r);
        end
      end
      S_SHIFT: begin
        if (k_inc < count_r) begin
          // Pull the next entry down over the gap.
          mem_we   = 1'b1;
          wptr_nxt = ptr_r;
          ptr_nxt  = wrap_inc(ptr_r);
          k_nxt    = k_inc;
        end else if (!out_busy) begin
          res_valid = 1'b1;
          count_nxt = count_dec;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
    ptr_r   <= ptr_nxt;
    wptr_r  <= wptr_nxt;
    k_r     <= k_nxt;
    find_r  <= find_nxt;
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

// ===== src/ordered_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | tdata                              | tuser
// in_     | slave     | [31:0] value                       | [2:0] mode
// out_    | master    | [31:0] popped_value, [38:32] count | [1:0] status
//
// Append, drop, length, clear, the unused mode and every full or empty refusal put
// a word in the result register in the cycle after acceptance. Pop reads the head
// entry first, find scans from the head to a match or the end, and delete scans and
// then pulls later entries down: one memory read port and one comparator walk the
// list an entry per cycle. Reset clears head and length; the store is not swept and
// no entry is read before it is written. A stalled result holds the block in place.
module ordered_list_engine #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [2:0]  in_tuser,   // [2:0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] popped_value, [38:32] count, [39] zero
  output logic [1:0]       out_tuser   // [1:0] status
);
  import ole_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r;
  logic               out_busy;
  logic               seq_idle;
  logic               accept;
  logic               res_valid;
  res_t               res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  // Hold the sequencer whenever a result word sits untaken.
  assign out_busy  = out_valid_r & ~out_tready;
  assign in_tready = seq_idle & ~out_busy;
  assign accept    = in_tvalid & in_tready;

  ole_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (accept),
    .cmd_mode  (in_tuser),
    .cmd_value (in_tdata),
    .out_busy  (out_busy),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ole_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Load on a new result, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.count, out_res_r.popped_value};
  assign out_tuser  = out_res_r.status;

endmodule
`default_nettype wire

// ===== src/ole_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_engine_macros.svh"
module ole_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [1:0]  out_tuser
);
  import ole_pkg::*;

  logic in_acc;

  assign in_acc = in_tvalid & in_tready;

  `OLE_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")
  `OLE_ASSERT_NXT(a_in_hold, in_tvalid && !in_tready,
    in_tvalid && $stable(in_tdata) && $stable(in_tuser), "input word changed while waiting")
  `OLE_ASSERT_NXT(a_result_or_busy, in_acc, out_tvalid || !in_tready,
    "accepted word neither answered nor held busy")
  `OLE_ASSERT_IMP(a_refused_zero, out_tvalid && out_tuser != ST_OK, out_tdata == 40'd0,
    "refused command carries data")
  `OLE_ASSERT_IMP(a_pop_no_count, out_tvalid && out_tdata[31:0] != 32'd0,
    out_tdata[38:32] == 7'd0, "pop result carries a count")

endmodule

bind ordered_list_engine ole_chk u_ole_chk (.*);
`default_nettype wire

// ===== test/ole_result_checker.sv =====
`timescale 1ns / 1ps
module ole_result_checker
  import ole_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          mismatches,
  output int          awaited
);

  localparam int DEPTH = DEPTH_DEF;

  // Shadow of the list: circular store, head slot and length.
  logic signed [VALUE_W-1:0] list_store [DEPTH];
  logic [$clog2(DEPTH)-1:0]  list_head;
  logic [COUNT_W-1:0]        list_len;
  res_t                      pending_results [$];

  // 0-based list position of the first match, or the length when absent.
  function automatic int position_of(logic signed [VALUE_W-1:0] v);
    for (int k = 0; k < list_len; k++) begin
      if (list_store[(list_head + k) % DEPTH] == v) return k;
    end
    return list_len;
  endfunction

  function automatic res_t predict_result(logic [MODE_W-1:0] mode,
                                          logic signed [VALUE_W-1:0] v);
    res_t r;
    int   k;
    r = '0;
    r.status = ST_OK;
    case (mode)
      MODE_APPEND: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_store[(list_head + list_len) % DEPTH] = v;
          list_len = list_len + 1;
        end
      end
      MODE_POP: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = list_store[list_head];
          list_head = (list_head + 1) % DEPTH;
          list_len = list_len - 1;
        end
      end
      MODE_DROP: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else list_len = list_len - 1;
      end
      MODE_DELETE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          k = position_of(v);
          if (k >= list_len) begin
            r.status = ST_NOTFOUND;
          end else begin
            // close the gap: later entries move one slot toward the head
            while (k + 1 < list_len) begin
              list_store[(list_head + k) % DEPTH] = list_store[(list_head + k + 1) % DEPTH];
              k++;
            end
            list_len = list_len - 1;
          end
        end
      end
      MODE_FIND: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          k = position_of(v);
          if (k >= list_len) r.status = ST_NOTFOUND;
          else r.count = COUNT_W'(k + 1);
        end
      end
      MODE_LENGTH: r.count = list_len;
      MODE_CLEAR: begin
        list_len  = '0;
        list_head = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t seen;
    res_t want;
    if (!rst_n) begin
      list_head  = '0;
      list_len   = '0;
      mismatches = 0;
      pending_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(predict_result(in_tuser, in_tdata));
      end
      if (out_tvalid && out_tready) begin
        seen.status       = out_tuser;
        seen.popped_value = out_tdata[31:0];
        seen.count        = out_tdata[38:32];
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none, actual status %0d popped %0d count %0d",
                   $time, seen.status, seen.popped_value, seen.count);
        end else begin
          want = pending_results.pop_front();
          if (seen.status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, seen.status);
          end
          if (seen.popped_value !== want.popped_value) begin
            mismatches++;
            $display("%0t: popped_value mismatch: expected %0d, actual %0d",
                     $time, want.popped_value, seen.popped_value);
          end
          if (seen.count !== want.count) begin
            mismatches++;
            $display("%0t: count mismatch: expected %0d, actual %0d",
                     $time, want.count, seen.count);
          end
          if (out_tdata[39] !== 1'b0) begin
            mismatches++;
            $display("%0t: tdata pad bit mismatch: expected 0, actual %b",
                     $time, out_tdata[39]);
          end
        end
      end
    end
    awaited = pending_results.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ole_pkg::*;

  // Mode seven has no name in the package; the block answers it with a plain ok.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  localparam logic [31:0] V_MIN  = 32'h8000_0000;
  localparam logic [31:0] V_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] V_ZERO = 32'h0000_0000;
  localparam logic [31:0] V_ONES = 32'hFFFF_FFFF;

  localparam int WORDS_WANTED = 1900;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic [2:0]  in_tuser = '0;   // [2:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] popped_value, [38:32] count, [39] zero
  logic [1:0]  out_tuser;       // [1:0] status
  int          mismatches;
  int          awaited;

  // Value pool for the current phase; a small pool makes hits and duplicates
  // common, a large one pushes finds and deletes deep into the list.
  logic [31:0] value_pool [64];
  int          pool_n;
  int          words_sent = 0;
  int          send_calm = 0;
  int          take_calm = 0;

  ordered_list_engine #(.DEPTH(DEPTH_DEF)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  ole_result_checker i_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random idle gap before the next word, with calm stretches of no gap at all.
  function automatic int pause_len(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 12);
  endfunction

  function automatic void refresh_pool();
    int r;
    pool_n = $urandom_range(4, 64);
    for (int i = 0; i < 64; i++) begin
      r = $urandom_range(0, 15);
      case (r)
        0:       value_pool[i] = V_MIN;
        1:       value_pool[i] = V_MAX;
        2:       value_pool[i] = V_ZERO;
        3:       value_pool[i] = V_ONES;
        default: value_pool[i] = $urandom;
      endcase
    end
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return value_pool[$urandom_range(0, pool_n - 1)];
    if (r == 7) return $urandom;
    return value_pool[$urandom_range(0, 3)];
  endfunction

  // Draw a mode from the phase's weights (append, pop, drop, delete, find,
  // length, clear, unused).
  function automatic logic [MODE_W-1:0] pick_mode(phase_t kind);
    int w [8];
    int total;
    int r;
    case (kind)
      PH_FILL:  w = '{90, 2, 1, 2, 3, 2, 0, 0};
      PH_DRAIN: w = '{6, 30, 20, 28, 10, 5, 0, 1};
      PH_MIXED: w = '{35, 12, 8, 15, 15, 8, 2, 5};
      default:  w = '{1, 1, 1, 1, 1, 1, 1, 1};
    endcase
    total = 0;
    foreach (w[i]) total += w[i];
    r = $urandom_range(0, total - 1);
    foreach (w[i]) begin
      if (r < w[i]) return MODE_W'(i);
      r -= w[i];
    end
    return MODE_UNUSED;
  endfunction

  // Offer one word and hold it until the block takes it. Entered and left at a
  // falling edge, so each step sees at most one assignment to in_tvalid.
  task automatic put_word(input logic [MODE_W-1:0] mode, input logic [31:0] value);
    int gap;
    gap = pause_len(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    @(negedge clk);
  endtask

  // Result side: stall a random count per word; twice, hold off for a long
  // stretch so the result register stays full and the block backs up its input.
  initial begin : drain_results
    int stall;
    int taken;
    taken = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = pause_len(take_calm);
      if (taken == 300 || taken == 1200) stall = 500;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : run_stimulus
    phase_t kind;
    int     run_len;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every refusal on the empty list, extreme values, duplicates,
    // hits and misses, delete of the head's value, the unused mode and clear.
    put_word(MODE_LENGTH, V_ZERO);
    put_word(MODE_POP,    V_ONES);
    put_word(MODE_DROP,   V_MAX);
    put_word(MODE_DELETE, V_MIN);
    put_word(MODE_FIND,   V_ZERO);
    put_word(MODE_APPEND, V_MIN);
    put_word(MODE_APPEND, V_MAX);
    put_word(MODE_APPEND, V_ZERO);
    put_word(MODE_APPEND, V_ONES);
    put_word(MODE_APPEND, V_MIN);
    put_word(MODE_FIND,   V_MAX);
    put_word(MODE_FIND,   V_ONES);
    put_word(MODE_FIND,   32'h0001_2345);
    put_word(MODE_DELETE, 32'h0000_0055);
    put_word(MODE_DELETE, V_MIN);
    put_word(MODE_LENGTH, V_ONES);
    put_word(MODE_POP,    V_ZERO);
    put_word(MODE_DROP,   V_ZERO);
    put_word(MODE_LENGTH, V_ZERO);
    put_word(MODE_UNUSED, 32'hA5A5_A5A5);
    put_word(MODE_CLEAR,  V_ONES);
    put_word(MODE_LENGTH, V_ZERO);
    put_word(MODE_APPEND, 32'h0000_0001);
    put_word(MODE_FIND,   32'h0000_0001);
    put_word(MODE_POP,    V_ZERO);

    // Random phases: fill runs drive the list to full and past it, drain runs
    // empty it, mixed runs walk the head around the ring, noise hits all modes.
    while (words_sent < WORDS_WANTED) begin
      refresh_pool();
      case ($urandom_range(0, 9))
        0, 1:       kind = PH_FILL;
        2, 3:       kind = PH_DRAIN;
        8:          kind = PH_NOISE;
        default:    kind = PH_MIXED;
      endcase
      case (kind)
        PH_FILL:  run_len = $urandom_range(60, 80);
        PH_DRAIN: run_len = $urandom_range(30, 80);
        PH_NOISE: run_len = $urandom_range(10, 30);
        default:  run_len = $urandom_range(20, 100);
      endcase
      if (kind == PH_MIXED && $urandom_range(0, 4) == 0) put_word(MODE_CLEAR, $urandom);
      for (int n = 0; n < run_len; n++) begin
        if (kind == PH_NOISE) put_word(pick_mode(kind), $urandom);
        else put_word(pick_mode(kind), pick_value());
      end
    end
    in_tvalid <= 1'b0;

    // Let the last words drain, then allow a full-list walk for stragglers.
    wait (awaited == 0);
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("** ordered_list_engine: PASSED **");
    end else begin
      $display("** ordered_list_engine: FAILED **");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #8_000_000;
    $display("** ordered_list_engine: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ole_pkg.sv
src/ole_mem.sv
src/ole_seq.sv
src/ordered_list_engine.sv
src/ole_chk.sv
test/ole_result_checker.sv
test/tb.sv
